// ----- sv/midi_note_event_parser_top_macros.svh -----
// ----------------------------------------------------------------------------
// MIDI note event parser - assertion macros
// Shorthand for clocked, reset-qualified concurrent assertions.
// ----------------------------------------------------------------------------
`ifndef MIDI_NOTE_EVENT_PARSER_TOP_MACROS_SVH
`define MIDI_NOTE_EVENT_PARSER_TOP_MACROS_SVH

// Same-cycle implication
`define MNEP_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mnep assertion failed");

// Next-cycle implication
`define MNEP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mnep assertion failed");

`endif

// ----- sv/mnep_pkg.sv -----
// ----------------------------------------------------------------------------
// MIDI note event parser - package
// Shared constants, message kind codes, the request type and note tables.
// ----------------------------------------------------------------------------
package mnep_pkg;

  localparam int MSG_BYTES = 3;
  localparam int CNT_W     = $clog2(MSG_BYTES + 1);
  localparam int IDX_W     = $clog2(MSG_BYTES);

  localparam logic [3:0] KIND_NOTE_OFF = 4'h8;
  localparam logic [3:0] KIND_NOTE_ON  = 4'h9;
  localparam logic [3:0] KIND_BEND     = 4'hE;

  localparam logic [4:0]  RANGE_RESET = 5'd2;
  localparam logic [13:0] BEND_OFFSET = 14'h2000;
  localparam logic [31:0] ROOT_ONE    = 32'h4000_0000;
  // floor(2^30 / 12)
  localparam logic [26:0] TWELFTH     = 27'd89478485;

  typedef struct packed {
    logic [6:0]  note;
    logic [13:0] bend;
    logic [4:0]  rng;
  } mnep_req_t;

  // Top octave A8..G#9 in Hz, truncated
  function automatic logic [13:0] top_octave(input logic [3:0] idx);
    logic [13:0] v;
    case (idx)
      4'd0:    v = 14'd7040;
      4'd1:    v = 14'd7458;
      4'd2:    v = 14'd7902;
      4'd3:    v = 14'd8372;
      4'd4:    v = 14'd8869;
      4'd5:    v = 14'd9397;
      4'd6:    v = 14'd9956;
      4'd7:    v = 14'd10548;
      4'd8:    v = 14'd11175;
      4'd9:    v = 14'd11839;
      4'd10:   v = 14'd12543;
      4'd11:   v = 14'd13289;
      default: v = 14'd0;
    endcase
    return v;
  endfunction

  // 1 + R/12 in Q30, truncated: R * 2^30 / 12 = R * TWELFTH + floor(R / 3)
  function automatic logic [31:0] root_zero(input logic [4:0] r);
    logic [31:0] p;
    logic [9:0]  d;
    p = 32'(r) * 32'(TWELFTH);
    d = 10'(r) * 10'd11;
    return ROOT_ONE + p + 32'(d[9:5]);
  endfunction

endpackage

// ----- sv/mnep_sqrt.sv -----
// ----------------------------------------------------------------------------
// MIDI note event parser - bit-serial square root
// floor(sqrt(arg * 2^30)), one root bit per cycle.
// ----------------------------------------------------------------------------
module mnep_sqrt (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] arg,
  output logic        done,
  output logic [30:0] root
);

  logic        busy;
  logic [4:0]  cnt;
  logic [61:0] nsh;
  logic [31:0] rem;
  logic [33:0] rem_sh;
  logic [33:0] trial;
  logic [33:0] diff;
  logic        ge;

  always_comb begin
    rem_sh = {rem, nsh[61:60]};
    trial  = {1'b0, root, 2'b01};
    diff   = rem_sh - trial;
    ge     = (rem_sh >= trial);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start && !busy) begin
        busy <= 1'b1;
        cnt  <= 5'd31;
        nsh  <= {arg, 30'd0};
        rem  <= 32'd0;
        root <= 31'd0;
      end else if (busy) begin
        nsh  <= {nsh[59:0], 2'b00};
        rem  <= ge ? diff[31:0] : rem_sh[31:0];
        root <= {root[29:0], ge};
        cnt  <= cnt - 5'd1;
        if (cnt == 5'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ----- sv/mnep_mul.sv -----
// ----------------------------------------------------------------------------
// MIDI note event parser - bit-serial multiplier
// 32 x 32 shift-and-add, multiplier bits taken MSB first.
// ----------------------------------------------------------------------------
module mnep_mul (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic        done,
  output logic [63:0] prod
);

  logic        busy;
  logic [5:0]  cnt;
  logic [31:0] mcand;
  logic [31:0] bsh;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start && !busy) begin
        busy  <= 1'b1;
        cnt   <= 6'd32;
        mcand <= a;
        bsh   <= b;
        prod  <= 64'd0;
      end else if (busy) begin
        prod <= {prod[62:0], 1'b0} + (bsh[31] ? {32'd0, mcand} : 64'd0);
        bsh  <= {bsh[30:0], 1'b0};
        cnt  <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ----- sv/mnep_div.sv -----
// ----------------------------------------------------------------------------
// MIDI note event parser - bit-serial reciprocal
// floor(2^60 / d), restoring division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module mnep_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] d,
  output logic        done,
  output logic [30:0] quot
);

  logic        busy;
  logic [5:0]  cnt;
  logic [31:0] dsr;
  logic [31:0] rem;
  logic [32:0] rem_sh;
  logic [32:0] diff;
  logic        ge;

  always_comb begin
    // numerator is a single one at bit 60, met on the first step
    rem_sh = {rem, (cnt == 6'd61)};
    diff   = rem_sh - {1'b0, dsr};
    ge     = (rem_sh >= {1'b0, dsr});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start && !busy) begin
        busy <= 1'b1;
        cnt  <= 6'd61;
        dsr  <= d;
        rem  <= 32'd0;
        quot <= 31'd0;
      end else if (busy) begin
        rem  <= ge ? diff[31:0] : rem_sh[31:0];
        quot <= {quot[29:0], ge};
        cnt  <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ----- sv/mnep_freq.sv -----
// ----------------------------------------------------------------------------
// MIDI note event parser - frequency engine
// Base note frequency times the pitch bend factor, sequenced over the
// serial root, multiply and reciprocal units.
// ----------------------------------------------------------------------------
module mnep_freq (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  mnep_pkg::mnep_req_t req,
  output logic                done,
  output logic [15:0]         freq
);

  localparam logic [3:0] F_IDLE  = 4'd0;
  localparam logic [3:0] F_BASE  = 4'd1;
  localparam logic [3:0] F_ROOT0 = 4'd2;
  localparam logic [3:0] F_SQRT  = 4'd3;
  localparam logic [3:0] F_PROD  = 4'd4;
  localparam logic [3:0] F_MULW  = 4'd5;
  localparam logic [3:0] F_FIN   = 4'd6;
  localparam logic [3:0] F_DIVW  = 4'd7;
  localparam logic [3:0] F_BMUL  = 4'd8;
  localparam logic [3:0] F_BMULW = 4'd9;

  localparam logic [3:0] LAST_ROOT = 4'd13;

  logic [3:0]  state;
  logic [7:0]  tone;
  logic [3:0]  oct;
  logic [13:0] bend;
  logic [4:0]  rng;
  logic [3:0]  k;
  logic [3:0]  j;
  logic [31:0] roots [14];
  logic [31:0] prod;

  logic        neg;
  logic [13:0] mag;
  logic [3:0]  shift;
  logic [13:0] base;
  logic [3:0]  ridx;

  logic        sq_start, sq_done;
  logic [31:0] sq_arg;
  logic [30:0] sq_root;
  logic        mul_start, mul_done;
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;
  logic        div_start, div_done;
  logic [30:0] div_q;

  always_comb begin
    neg    = bend[13];
    mag    = neg ? (14'd0 - bend) : bend;
    shift  = (oct >= 4'd10) ? 4'd0 : (4'd10 - oct);
    base   = mnep_pkg::top_octave(tone[3:0]) >> shift;
    ridx   = LAST_ROOT - j;

    sq_start  = (state == F_ROOT0) || ((state == F_SQRT) && sq_done && (k != LAST_ROOT));
    sq_arg    = (state == F_ROOT0) ? mnep_pkg::root_zero(rng) : {1'b0, sq_root};
    mul_start = ((state == F_PROD) && mag[j]) || (state == F_BMUL);
    mul_a     = (state == F_BMUL) ? {18'd0, base} : prod;
    mul_b     = (state == F_BMUL) ? {14'd0, prod[31:14]} : roots[ridx];
    div_start = (state == F_FIN) && neg;
  end

  mnep_sqrt u_sqrt (
    .clk   (clk),
    .rst   (rst),
    .start (sq_start),
    .arg   (sq_arg),
    .done  (sq_done),
    .root  (sq_root)
  );

  mnep_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (mul_p)
  );

  mnep_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .d     (prod),
    .done  (div_done),
    .quot  (div_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        F_IDLE: begin
          if (start) begin
            tone  <= {1'b0, req.note} + 8'd3;
            oct   <= 4'd0;
            bend  <= req.bend;
            rng   <= req.rng;
            state <= F_BASE;
          end
        end
        F_BASE: begin
          // split note + 3 into octave and pitch class by repeated subtraction
          if (tone >= 8'd12) begin
            tone <= tone - 8'd12;
            oct  <= oct + 4'd1;
          end else begin
            state <= F_ROOT0;
          end
        end
        F_ROOT0: begin
          roots[0] <= mnep_pkg::root_zero(rng);
          k        <= 4'd1;
          state    <= F_SQRT;
        end
        F_SQRT: begin
          if (sq_done) begin
            roots[k] <= {1'b0, sq_root};
            if (k == LAST_ROOT) begin
              prod  <= mnep_pkg::ROOT_ONE;
              j     <= 4'd0;
              state <= F_PROD;
            end else begin
              k <= k + 4'd1;
            end
          end
        end
        F_PROD: begin
          if (mag[j]) begin
            state <= F_MULW;
          end else if (j == LAST_ROOT) begin
            state <= F_FIN;
          end else begin
            j <= j + 4'd1;
          end
        end
        F_MULW: begin
          if (mul_done) begin
            prod <= mul_p[61:30];
            if (j == LAST_ROOT) begin
              state <= F_FIN;
            end else begin
              j     <= j + 4'd1;
              state <= F_PROD;
            end
          end
        end
        F_FIN: begin
          state <= neg ? F_DIVW : F_BMUL;
        end
        F_DIVW: begin
          if (div_done) begin
            prod  <= {1'b0, div_q};
            state <= F_BMUL;
          end
        end
        F_BMUL: begin
          state <= F_BMULW;
        end
        F_BMULW: begin
          if (mul_done) begin
            freq  <= (|mul_p[63:32]) ? 16'hFFFF : mul_p[31:16];
            done  <= 1'b1;
            state <= F_IDLE;
          end
        end
        default: begin
          state <= F_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- sv/midi_note_event_parser_top.sv -----
// ----------------------------------------------------------------------------
// MIDI note event parser - top level
// Collects MIDI bytes into a message buffer, evaluates it on a tick and
// emits note events carrying the pitch-bent frequency.
// ----------------------------------------------------------------------------
//  Channel   Direction  Payload
//  s_*       in         tuser = mode (1 = tick), tdata = byte_value
//  m_*       out        tuser = is_note_on, tdata = event fields (see port)
//  cfg_*     in         pitch_range_semitones, written whenever cfg_we is high
//
//  A byte beat goes straight into the message buffer; s_tready stays high between events.
//  A tick that yields an event holds s_tready low while the frequency is
//  formed and until the event moves into the output register. The event
//  then waits in the output register until m_tready takes it; byte beats
//  are accepted meanwhile. The frequency chain includes thirteen bit-serial
//  square roots.
//  Reset (rst, synchronous) clears the buffer, all channel bends and sets the
//  bend range to two semitones.
// ----------------------------------------------------------------------------
module midi_note_event_parser_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] byte_value
  input  logic        s_tuser,   // [0] mode
  output logic        m_tvalid,
  input  logic        m_tready,
  // [3:0] channel, [10:4] note_number, [17:11] velocity, [33:18] frequency_hz,
  // [41:34] status_byte, [43:42] message_length, [47:44] zero
  output logic [47:0] m_tdata,
  output logic        m_tuser,   // [0] is_note_on
  input  logic        cfg_we,
  input  logic [4:0]  cfg_wdata
);

  localparam int CNT_W = mnep_pkg::CNT_W;
  localparam int IDX_W = mnep_pkg::IDX_W;

  // Control states of the top level
  localparam logic [1:0] T_IDLE = 2'd0;
  localparam logic [1:0] T_CALC = 2'd1;
  localparam logic [1:0] T_HOLD = 2'd2;

  logic [1:0]       tstate;
  logic [4:0]       rng;
  logic [3:0]       kind;
  logic [3:0]       chan;
  logic [7:0]       slots [mnep_pkg::MSG_BYTES];
  logic [CNT_W-1:0] count;
  logic [13:0]      bends [16];

  // Event fields held while the frequency is formed
  logic             on_h;
  logic [3:0]       chan_h;
  logic [6:0]       note_h;
  logic [6:0]       vel_h;
  logic [7:0]       status_h;
  logic [1:0]       len_h;

  logic                beat;
  logic                tick;
  logic                is_on;
  logic                is_off;
  logic                is_bend;
  logic                fire;
  logic                bend_wr;
  logic                drop;
  logic                load;
  logic                eng_done;
  logic [15:0]         eng_freq;
  mnep_pkg::mnep_req_t eng_req;

  assign s_tready = (tstate == T_IDLE);

  always_comb begin
    beat    = s_tvalid && s_tready;
    tick    = beat && s_tuser && (count != '0);
    is_on   = (kind == mnep_pkg::KIND_NOTE_ON);
    is_off  = (kind == mnep_pkg::KIND_NOTE_OFF);
    is_bend = (kind == mnep_pkg::KIND_BEND);
    // note-on needs a full message, note-off only status and note
    fire    = tick && ((is_on && (count >= CNT_W'(3))) || (is_off && (count >= CNT_W'(2))));
    bend_wr = tick && is_bend && (count >= CNT_W'(3));
    // anything that is not a note or bend message is thrown away
    drop    = tick && !is_on && !is_off && !is_bend;
    load    = (tstate == T_HOLD) && (!m_tvalid || m_tready);

    eng_req.note = slots[1][6:0];
    eng_req.bend = bends[chan];
    eng_req.rng  = rng;
  end

  mnep_freq u_freq (
    .clk   (clk),
    .rst   (rst),
    .start (fire),
    .req   (eng_req),
    .done  (eng_done),
    .freq  (eng_freq)
  );

  // Bend range register
  always_ff @(posedge clk) begin
    if (rst) begin
      rng <= mnep_pkg::RANGE_RESET;
    end else if (cfg_we) begin
      rng <= cfg_wdata;
    end
  end

  // Message buffer and per-channel bend
  always_ff @(posedge clk) begin
    if (rst) begin
      kind  <= 4'd0;
      chan  <= 4'd0;
      count <= '0;
      for (int i = 0; i < mnep_pkg::MSG_BYTES; i++) begin
        slots[i] <= 8'd0;
      end
      for (int c = 0; c < 16; c++) begin
        bends[c] <= 14'd0;
      end
    end else if (beat && !s_tuser) begin
      if (s_tdata[7]) begin
        // status byte: start a new message
        kind     <= s_tdata[7:4];
        chan     <= s_tdata[3:0];
        slots[0] <= s_tdata;
        count    <= CNT_W'(1);
      end else if (count < CNT_W'(mnep_pkg::MSG_BYTES)) begin
        // data byte: append, drop it once the buffer is full
        slots[count[IDX_W-1:0]] <= s_tdata;
        count                   <= count + CNT_W'(1);
      end
    end else begin
      if (bend_wr) begin
        bends[chan] <= {slots[2][6:0], slots[1][6:0]} ^ mnep_pkg::BEND_OFFSET;
      end
      if (fire || bend_wr || drop) begin
        count <= '0;
      end
    end
  end

  // Capture event fields as the engine starts
  always_ff @(posedge clk) begin
    if (fire) begin
      on_h     <= is_on;
      chan_h   <= chan;
      note_h   <= slots[1][6:0];
      vel_h    <= slots[2][6:0];
      status_h <= slots[0];
      len_h    <= 2'(count);
    end
  end

  // Sequencing and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      tstate   <= T_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      case (tstate)
        T_IDLE: begin
          if (fire) begin
            tstate <= T_CALC;
          end
        end
        T_CALC: begin
          if (eng_done) begin
            tstate <= T_HOLD;
          end
        end
        T_HOLD: begin
          if (load) begin
            tstate <= T_IDLE;
          end
        end
        default: begin
          tstate <= T_IDLE;
        end
      endcase
      if (load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_tuser <= on_h;
      m_tdata <= {4'd0, len_h, status_h, eng_freq, vel_h, note_h, chan_h};
    end
  end

endmodule

// ----- sv/mnep_checker.sv -----
// ----------------------------------------------------------------------------
// MIDI note event parser - port checker
// Watches the stream ports of the top level over time.
// ----------------------------------------------------------------------------
`include "midi_note_event_parser_top_macros.svh"

module mnep_port_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        s_tuser,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [47:0] m_tdata,
  input logic        m_tuser
);

  // Hold a stalled event
  `MNEP_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

  // A byte beat never raises an event
  `MNEP_ASSERT_NEXT(a_byte_quiet, s_tvalid && s_tready && !s_tuser && !m_tvalid, !m_tvalid)

  // Note-on events come only from complete messages
  `MNEP_ASSERT_NOW(a_on_len, m_tvalid && m_tuser, m_tdata[43:42] == 2'd3)

  // Any event carries at least status and note
  `MNEP_ASSERT_NOW(a_len_min, m_tvalid, m_tdata[43:42] == 2'd2 || m_tdata[43:42] == 2'd3)

endmodule

bind midi_note_event_parser_top mnep_port_checker u_mnep_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
